### rtl/two_fluid_plasma_flux_top_defines.svh
// assertion macros shared by the two-fluid flux rtl
`ifndef TWO_FLUID_PLASMA_FLUX_TOP_DEFINES_SVH
`define TWO_FLUID_PLASMA_FLUX_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define TFPF_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed: label");
`define TFPF_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed: label");
`else
`define TFPF_ASSERT(label, clk, rstn, prop)
`define TFPF_ASSERT_RST(label, clk, prop)
`endif
`endif

### rtl/tfpf_pkg.sv
// package with constants and fixed-point helpers for the two-fluid flux block
package tfpf_pkg;
    localparam int FRAC_BITS = 16;
    localparam int DIV_BITS  = 48;
    localparam int NUM_REGS  = 2;
    localparam logic [0:0] REG_GAMMA = 1'd0;
    localparam logic [0:0] REG_LIGHT = 1'd1;
    localparam logic [18:0] GAMMA_RESET = 19'd109227;
    localparam logic [23:0] LIGHT_RESET = 24'd655360;
    localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] WORD_MIN = 32'sh80000000;

    // saturate a 34-bit sum to the word range
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > 34'(WORD_MAX)) return WORD_MAX;
        if (v < 34'(WORD_MIN)) return WORD_MIN;
        return v[31:0];
    endfunction

    // saturate a 50-bit value to the word range
    function automatic logic signed [31:0] sat50(input logic signed [49:0] v);
        if (v > 50'(WORD_MAX)) return WORD_MAX;
        if (v < 50'(WORD_MIN)) return WORD_MIN;
        return v[31:0];
    endfunction

    // fixed-point product, floor shift, saturated
    function automatic logic signed [31:0] qmul(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
        logic signed [65:0] p;
        p = a * b;
        return sat50(p[65:FRAC_BITS]);
    endfunction

    // saturated add
    function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return sat34(34'(a) + 34'(b));
    endfunction
endpackage

### rtl/two_fluid_plasma_flux_top.sv
// top level of the two-fluid plasma flux pipeline
//
// Streaming block: one species state per input beat on s_ (density, three
// momenta, energy, By, Bz, Ey, Ez), one flux beat per input beat on m_ (five
// Euler fluxes and four Maxwell fluxes), in the same order.
// Throughput is one beat per clock while not stalled. An input beat passes one
// capture stage, 48 restoring divider stages that resolve one quotient bit each
// for the three velocities, then eight arithmetic stages with at most one
// multiply between registers. The gamma and speed-of-light registers are written
// through the cfg_ port; the user must do so only while the pipeline is empty
// (the block does not enforce it); light speed squared is registered next cycle.
// The whole pipeline advances together; when the output beat is held by
// m_tready low, s_tready drops and every stage keeps its contents, so no beat
// is lost or repeated.
// aresetn (synchronous, active low) clears all valid bits and restores the
// register defaults: gamma five thirds, light speed ten.
// Zero density gives zero velocities; all results saturate to 32 bits.
`include "two_fluid_plasma_flux_top_defines.svh"
module two_fluid_plasma_flux_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [0:0]   cfg_addr,
    input  logic [23:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // density, momentum_x, momentum_y, momentum_z, total_energy, mag_y, mag_z,
    // elec_y, elec_z, one pad bit
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // flux_mass, flux_mom_x, flux_mom_y, flux_mom_z, flux_energy, flux_mag_y,
    // flux_mag_z, flux_elec_y, flux_elec_z
    output logic [287:0] m_tdata
);
    import tfpf_pkg::*;

    typedef struct packed {
        logic                    v;
        logic [30:0]             rho;
        logic [2:0]              neg;
        logic [2:0][30:0]        rem;
        logic [2:0][DIV_BITS-1:0] q;
        logic [31:0]             en;
        logic [31:0]             by;
        logic [31:0]             bz;
        logic [31:0]             ey;
        logic [31:0]             ez;
    } dv_t;

    // one restoring division step on all three lanes
    function automatic dv_t div_step(input dv_t d);
        dv_t r;
        logic [31:0] t;
        r = d;
        for (int i = 0; i < 3; i++) begin
            t = {d.rem[i], d.q[i][DIV_BITS-1]};
            if (t >= {1'b0, d.rho}) begin
                r.rem[i] = 31'(t - {1'b0, d.rho});
                r.q[i] = {d.q[i][DIV_BITS-2:0], 1'b1};
            end else begin
                r.rem[i] = t[30:0];
                r.q[i] = {d.q[i][DIV_BITS-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    logic [18:0] gamma_reg;
    logic [23:0] light_reg;
    logic signed [31:0] c2_reg;
    logic adv;

    dv_t dv_reg [0:DIV_BITS];
    dv_t dv_next;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gamma_reg <= GAMMA_RESET;
            light_reg <= LIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_GAMMA: gamma_reg <= cfg_wdata[18:0];
                REG_LIGHT: light_reg <= cfg_wdata;
                default:   gamma_reg <= gamma_reg;
            endcase
        end
    end

    // light speed squared
    always_ff @(posedge aclk) begin
        c2_reg <= qmul(33'({9'd0, light_reg}), 33'({9'd0, light_reg}));
    end

    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    // capture stage: magnitudes of the scaled momenta
    always_comb begin
        logic signed [31:0] m;
        logic [31:0] mag;
        dv_next = '0;
        dv_next.v = s_tvalid;
        dv_next.rho = s_tdata[30:0];
        dv_next.en = s_tdata[158:127];
        dv_next.by = s_tdata[190:159];
        dv_next.bz = s_tdata[222:191];
        dv_next.ey = s_tdata[254:223];
        dv_next.ez = s_tdata[286:255];
        for (int i = 0; i < 3; i++) begin
            m = s_tdata[31 + 32*i +: 32];
            mag = m[31] ? 32'(-m) : m;
            dv_next.neg[i] = m[31];
            dv_next.q[i] = {mag, 16'd0};
        end
    end

    // divider chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DIV_BITS; k++) dv_reg[k].v <= 1'b0;
        end else if (adv) begin
            dv_reg[0] <= dv_next;
            for (int k = 0; k < DIV_BITS; k++) dv_reg[k+1] <= div_step(dv_reg[k]);
        end
    end

    // stage a: signed, saturated velocities
    logic a_v_reg;
    logic signed [31:0] a_u_reg [0:2];
    logic [30:0] a_rho_reg;
    logic [31:0] a_en_reg, a_by_reg, a_bz_reg, a_ey_reg, a_ez_reg;
    always_ff @(posedge aclk) begin
        logic signed [49:0] qv;
        if (!aresetn) a_v_reg <= 1'b0;
        else if (adv) a_v_reg <= dv_reg[DIV_BITS].v;
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                qv = {2'b00, dv_reg[DIV_BITS].q[i]};
                if (dv_reg[DIV_BITS].neg[i]) qv = -qv;
                a_u_reg[i] <= (dv_reg[DIV_BITS].rho == '0) ? 32'sd0 : sat50(qv);
            end
            a_rho_reg <= dv_reg[DIV_BITS].rho;
            a_en_reg <= dv_reg[DIV_BITS].en;
            a_by_reg <= dv_reg[DIV_BITS].by;
            a_bz_reg <= dv_reg[DIV_BITS].bz;
            a_ey_reg <= dv_reg[DIV_BITS].ey;
            a_ez_reg <= dv_reg[DIV_BITS].ez;
        end
    end

    // stage b: squares and mass flux
    logic b_v_reg;
    logic signed [31:0] b_sq_reg [0:2];
    logic signed [31:0] b_u_reg [0:2];
    logic signed [31:0] b_fm_reg;
    logic [30:0] b_rho_reg;
    logic [31:0] b_en_reg, b_by_reg, b_bz_reg, b_ey_reg, b_ez_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) b_v_reg <= 1'b0;
        else if (adv) b_v_reg <= a_v_reg;
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                b_sq_reg[i] <= qmul(33'(a_u_reg[i]), 33'(a_u_reg[i]));
                b_u_reg[i] <= a_u_reg[i];
            end
            b_fm_reg <= qmul(33'({2'b00, a_rho_reg}), 33'(a_u_reg[0]));
            b_rho_reg <= a_rho_reg;
            b_en_reg <= a_en_reg;
            b_by_reg <= a_by_reg;
            b_bz_reg <= a_bz_reg;
            b_ey_reg <= a_ey_reg;
            b_ez_reg <= a_ez_reg;
        end
    end

    // stage c: sum of squares
    logic c_v_reg;
    logic signed [31:0] c_s_reg, c_fm_reg;
    logic signed [31:0] c_u_reg [0:2];
    logic [30:0] c_rho_reg;
    logic [31:0] c_en_reg, c_by_reg, c_bz_reg, c_ey_reg, c_ez_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) c_v_reg <= 1'b0;
        else if (adv) c_v_reg <= b_v_reg;
        if (adv) begin
            c_s_reg <= sadd(sadd(b_sq_reg[0], b_sq_reg[1]), b_sq_reg[2]);
            c_fm_reg <= b_fm_reg;
            for (int i = 0; i < 3; i++) c_u_reg[i] <= b_u_reg[i];
            c_rho_reg <= b_rho_reg;
            c_en_reg <= b_en_reg;
            c_by_reg <= b_by_reg;
            c_bz_reg <= b_bz_reg;
            c_ey_reg <= b_ey_reg;
            c_ez_reg <= b_ez_reg;
        end
    end

    // stage d: rho times speed squared
    logic d_v_reg;
    logic signed [31:0] d_k_reg, d_fm_reg;
    logic signed [31:0] d_u_reg [0:2];
    logic [31:0] d_en_reg, d_by_reg, d_bz_reg, d_ey_reg, d_ez_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) d_v_reg <= 1'b0;
        else if (adv) d_v_reg <= c_v_reg;
        if (adv) begin
            d_k_reg <= qmul(33'({2'b00, c_rho_reg}), 33'(c_s_reg));
            d_fm_reg <= c_fm_reg;
            for (int i = 0; i < 3; i++) d_u_reg[i] <= c_u_reg[i];
            d_en_reg <= c_en_reg;
            d_by_reg <= c_by_reg;
            d_bz_reg <= c_bz_reg;
            d_ey_reg <= c_ey_reg;
            d_ez_reg <= c_ez_reg;
        end
    end

    // stage e: internal energy
    logic e_v_reg;
    logic signed [31:0] e_t_reg, e_fm_reg;
    logic signed [31:0] e_u_reg [0:2];
    logic [31:0] e_en_reg, e_by_reg, e_bz_reg, e_ey_reg, e_ez_reg;
    always_ff @(posedge aclk) begin
        logic signed [31:0] h;
        h = d_k_reg >>> 1;
        if (!aresetn) e_v_reg <= 1'b0;
        else if (adv) e_v_reg <= d_v_reg;
        if (adv) begin
            e_t_reg <= sat34(34'($signed(d_en_reg)) - 34'(h));
            e_fm_reg <= d_fm_reg;
            for (int i = 0; i < 3; i++) e_u_reg[i] <= d_u_reg[i];
            e_en_reg <= d_en_reg;
            e_by_reg <= d_by_reg;
            e_bz_reg <= d_bz_reg;
            e_ey_reg <= d_ey_reg;
            e_ez_reg <= d_ez_reg;
        end
    end

    // stage f: pressure, momentum and field products
    logic f_v_reg;
    logic signed [31:0] f_p_reg, f_fm_reg, f_mx_reg, f_my_reg, f_mz_reg;
    logic signed [31:0] f_u1_reg, f_ely_reg, f_elz_reg;
    logic [31:0] f_en_reg, f_ey_reg, f_ez_reg;
    always_ff @(posedge aclk) begin
        logic signed [32:0] gm1;
        gm1 = 33'({14'd0, gamma_reg}) - 33'(34'sd65536);
        if (!aresetn) f_v_reg <= 1'b0;
        else if (adv) f_v_reg <= e_v_reg;
        if (adv) begin
            f_p_reg <= qmul(gm1, 33'(e_t_reg));
            f_mx_reg <= qmul(33'(e_fm_reg), 33'(e_u_reg[0]));
            f_my_reg <= qmul(33'(e_fm_reg), 33'(e_u_reg[1]));
            f_mz_reg <= qmul(33'(e_fm_reg), 33'(e_u_reg[2]));
            f_ely_reg <= qmul(33'(c2_reg), 33'($signed(e_bz_reg)));
            f_elz_reg <= qmul(-33'(c2_reg), 33'($signed(e_by_reg)));
            f_fm_reg <= e_fm_reg;
            f_u1_reg <= e_u_reg[0];
            f_en_reg <= e_en_reg;
            f_ey_reg <= e_ey_reg;
            f_ez_reg <= e_ez_reg;
        end
    end

    // stage g: sums with pressure, maxwell negation
    logic g_v_reg;
    logic signed [31:0] g_fm_reg, g_mx_reg, g_my_reg, g_mz_reg, g_ep_reg, g_u1_reg;
    logic signed [31:0] g_by_reg, g_bz_reg, g_ely_reg, g_elz_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) g_v_reg <= 1'b0;
        else if (adv) g_v_reg <= f_v_reg;
        if (adv) begin
            g_fm_reg <= f_fm_reg;
            g_mx_reg <= sadd(f_mx_reg, f_p_reg);
            g_my_reg <= f_my_reg;
            g_mz_reg <= f_mz_reg;
            g_ep_reg <= sadd($signed(f_en_reg), f_p_reg);
            g_u1_reg <= f_u1_reg;
            g_by_reg <= sat34(-34'($signed(f_ez_reg)));
            g_bz_reg <= f_ey_reg;
            g_ely_reg <= f_ely_reg;
            g_elz_reg <= f_elz_reg;
        end
    end

    // stage h: energy flux, output register
    logic h_v_reg;
    logic [287:0] h_data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) h_v_reg <= 1'b0;
        else if (adv) h_v_reg <= g_v_reg;
        if (adv) begin
            h_data_reg <= {g_elz_reg, g_ely_reg, g_bz_reg, g_by_reg,
                           qmul(33'(g_u1_reg), 33'(g_ep_reg)),
                           g_mz_reg, g_my_reg, g_mx_reg, g_fm_reg};
        end
    end

    assign m_tvalid = h_v_reg;
    assign m_tdata = h_data_reg;

    `TFPF_ASSERT(a_stall_blocks_input, aclk, aresetn, (m_tvalid && !m_tready) |-> !s_tready)
    `TFPF_ASSERT_RST(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid)
    `TFPF_ASSERT(a_c2_nonneg, aclk, aresetn, !c2_reg[31])
    `TFPF_ASSERT(a_accept_enters, aclk, aresetn, (s_tvalid && s_tready) |=> dv_reg[0].v)
endmodule
